### rtl/abrf_pkg.sv
package abrf_pkg;

   localparam logic [31:0] STATUS_AT_RESET = 32'h0000_00d3;
   localparam logic [4:0]  MODE_MASK       = 5'h1f;

   localparam logic [4:0] MODE_FIQ = 5'h11;
   localparam logic [4:0] MODE_IRQ = 5'h12;
   localparam logic [4:0] MODE_SVC = 5'h13;
   localparam logic [4:0] MODE_ABT = 5'h17;
   localparam logic [4:0] MODE_UND = 5'h1b;

   localparam logic [3:0] REG_R8  = 4'd8;
   localparam logic [3:0] REG_R13 = 4'd13;
   localparam logic [3:0] REG_R14 = 4'd14;

   typedef enum logic [2:0] {
      KIND_READ_REG   = 3'd0,
      KIND_WRITE_REG  = 3'd1,
      KIND_SET_MODE   = 3'd2,
      KIND_READ_SPSR  = 3'd3,
      KIND_WRITE_SPSR = 3'd4
   } req_kind_type;

   typedef enum logic [2:0] {
      BANK_USR = 3'd0,
      BANK_FIQ = 3'd1,
      BANK_IRQ = 3'd2,
      BANK_SVC = 3'd3,
      BANK_ABT = 3'd4,
      BANK_UND = 3'd5
   } bank_type;

   typedef struct packed {
      logic       wr_en;
      logic [3:0] idx;
      bank_type   bank;
   } gpr_op_type;

   typedef struct packed {
      logic         valid;
      req_kind_type kind;
      logic [4:0]   mode;
   } psr_op_type;

   function automatic bank_type bank_of(input logic [4:0] mode);
      bank_type b;
      b = BANK_USR;
      case (mode)
         MODE_FIQ: b = BANK_FIQ;
         MODE_IRQ: b = BANK_IRQ;
         MODE_SVC: b = BANK_SVC;
         MODE_ABT: b = BANK_ABT;
         MODE_UND: b = BANK_UND;
         default:  b = BANK_USR;
      endcase
      return b;
   endfunction

endpackage

### rtl/abrf_gpr.sv
module abrf_gpr (
   input  logic               clock,
   input  logic               reset,
   input  abrf_pkg::gpr_op_type op,
   input  logic [31:0]        wr_data,
   output logic [31:0]        rd_data
);

   logic [31:0] user_ff [16];
   logic [31:0] fiq_ff  [7];
   logic [31:0] priv_ff [4][2];

   logic       in_fiq;
   logic       in_priv;
   logic [2:0] fiq_sel;
   logic [1:0] priv_bank;
   logic       priv_slot;

   always_comb begin
      in_fiq    = (op.bank == abrf_pkg::BANK_FIQ) && (op.idx >= abrf_pkg::REG_R8)
                  && (op.idx <= abrf_pkg::REG_R14);
      in_priv   = (op.bank != abrf_pkg::BANK_FIQ) && (op.bank != abrf_pkg::BANK_USR)
                  && ((op.idx == abrf_pkg::REG_R13) || (op.idx == abrf_pkg::REG_R14));
      fiq_sel   = op.idx[2:0];
      priv_bank = 2'(op.bank - abrf_pkg::BANK_IRQ);
      priv_slot = op.idx[1];
   end

   always_comb begin
      if (in_fiq) begin
         rd_data = fiq_ff[fiq_sel];
      end else if (in_priv) begin
         rd_data = priv_ff[priv_bank][priv_slot];
      end else begin
         rd_data = user_ff[op.idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) user_ff[i] <= '0;
         for (int i = 0; i < 7; i++) fiq_ff[i] <= '0;
         for (int b = 0; b < 4; b++) begin
            priv_ff[b][0] <= '0;
            priv_ff[b][1] <= '0;
         end
      end else if (op.wr_en) begin
         if (in_fiq) begin
            fiq_ff[fiq_sel] <= wr_data;
         end else if (in_priv) begin
            priv_ff[priv_bank][priv_slot] <= wr_data;
         end else begin
            user_ff[op.idx] <= wr_data;
         end
      end
   end

endmodule

### rtl/abrf_psr.sv
module abrf_psr (
   input  logic               clock,
   input  logic               reset,
   input  abrf_pkg::psr_op_type op,
   input  logic [31:0]        wr_data,
   output abrf_pkg::bank_type bank,
   output logic [31:0]        spsr_rd,
   output logic [31:0]        cpsr_in
);

   logic [31:0] cpsr_ff;
   logic [31:0] spsr_ff [5];
   logic [2:0]  spsr_sel;

   always_comb begin
      bank     = abrf_pkg::bank_of(cpsr_ff[4:0]);
      spsr_sel = 3'(bank - abrf_pkg::BANK_FIQ);
      spsr_rd  = (bank == abrf_pkg::BANK_USR) ? cpsr_ff : spsr_ff[spsr_sel];
      cpsr_in  = cpsr_ff;
      if (op.valid && (op.kind == abrf_pkg::KIND_SET_MODE)) begin
         cpsr_in = {cpsr_ff[31:5], op.mode & abrf_pkg::MODE_MASK};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cpsr_ff <= abrf_pkg::STATUS_AT_RESET;
         for (int i = 0; i < 5; i++) spsr_ff[i] <= '0;
      end else begin
         cpsr_ff <= cpsr_in;
         if (op.valid && (op.kind == abrf_pkg::KIND_WRITE_SPSR)
             && (bank != abrf_pkg::BANK_USR)) begin
            spsr_ff[spsr_sel] <= wr_data;
         end
      end
   end

endmodule

### rtl/arm_banked_register_file.sv
// channel  | ports                                               | handshake
// ---------+-----------------------------------------------------+---------------------
// request  | req_type req_reg_index req_write_data req_new_mode  | start && !busy
// response | rsp_read_data rsp_current_mode rsp_status_word      | rsp_valid, 1 cycle
//
// One beat per cycle while busy is low; a request beat is captured in the request
// register and its response in the response register, with the bank decode and
// register read between them; mode changes only rewrite the CPSR mode field.
// Reset clears the GPRs and SPSRs, loads CPSR 0xd3 (SVC); busy is high for one cycle.
// The receiver cannot stall: busy never rises after reset.
module arm_banked_register_file (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_type,
   input  logic [3:0]  req_reg_index,
   input  logic [31:0] req_write_data,
   input  logic [4:0]  req_new_mode,
   output logic        rsp_valid,
   output logic [31:0] rsp_read_data,
   output logic [4:0]  rsp_current_mode,
   output logic [31:0] rsp_status_word
);

   logic                   busy_ff;
   logic                   req_valid_ff;
   abrf_pkg::req_kind_type req_kind_ff;
   logic [3:0]             req_idx_ff;
   logic [31:0]            req_data_ff;
   logic [4:0]             req_mode_ff;

   logic                   rsp_valid_ff;
   logic [31:0]            rsp_read_data_ff, rsp_read_data_in;
   logic [31:0]            rsp_status_ff;

   abrf_pkg::gpr_op_type   gpr_op;
   abrf_pkg::psr_op_type   psr_op;
   abrf_pkg::bank_type     bank;
   logic [31:0]            gpr_rd;
   logic [31:0]            spsr_rd;
   logic [31:0]            cpsr_in;
   logic                   accept;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         req_valid_ff <= accept;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_kind_ff <= abrf_pkg::req_kind_type'(req_type);
         req_idx_ff  <= req_reg_index;
         req_data_ff <= req_write_data;
         req_mode_ff <= req_new_mode;
      end
      rsp_read_data_ff <= rsp_read_data_in;
      rsp_status_ff    <= cpsr_in;
   end

   always_comb begin
      gpr_op.wr_en = req_valid_ff && (req_kind_ff == abrf_pkg::KIND_WRITE_REG);
      gpr_op.idx   = req_idx_ff;
      gpr_op.bank  = bank;
      psr_op.valid = req_valid_ff;
      psr_op.kind  = req_kind_ff;
      psr_op.mode  = req_mode_ff;
   end

   always_comb begin
      case (req_kind_ff)
         abrf_pkg::KIND_READ_REG:  rsp_read_data_in = gpr_rd;
         abrf_pkg::KIND_READ_SPSR: rsp_read_data_in = spsr_rd;
         default:                  rsp_read_data_in = '0;
      endcase
   end

   abrf_gpr u_gpr (
      .clock   (clock),
      .reset   (reset),
      .op      (gpr_op),
      .wr_data (req_data_ff),
      .rd_data (gpr_rd)
   );

   abrf_psr u_psr (
      .clock   (clock),
      .reset   (reset),
      .op      (psr_op),
      .wr_data (req_data_ff),
      .bank    (bank),
      .spsr_rd (spsr_rd),
      .cpsr_in (cpsr_in)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_read_data_ff;
   assign rsp_status_word  = rsp_status_ff;
   assign rsp_current_mode = rsp_status_ff[4:0];

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff |=> rsp_valid)
      else $error("request beat produced no response");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !req_valid_ff |=> !rsp_valid)
      else $error("response without request beat");

   a_write_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && (req_kind_ff == abrf_pkg::KIND_WRITE_REG
                        || req_kind_ff == abrf_pkg::KIND_WRITE_SPSR
                        || req_kind_ff == abrf_pkg::KIND_SET_MODE))
      |=> (rsp_read_data == 32'd0))
      else $error("non-read request returned data");

   a_cpsr_upper_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff |=> (rsp_status_word[31:5] == $past(cpsr_in[31:5])))
      else $error("CPSR control bits changed");

endmodule
